### rtl/vrsm_pkg.sv
`default_nettype none

package vrsm_pkg;

  localparam int MODE_W   = 3;
  localparam int VREG_W   = 8;
  localparam int RIDX_W   = 2;
  localparam int PREG_W   = 2;
  localparam int STATUS_W = 2;
  localparam int OFF_W    = 7;
  localparam int DEPTH_W  = 5;

  localparam int SLOT_BYTES = 4;
  localparam logic [DEPTH_W-1:0] DEPTH_MAX = 5'd31;

  localparam logic [MODE_W-1:0] MODE_GET_FREE    = 3'd0;
  localparam logic [MODE_W-1:0] MODE_RESTORE     = 3'd1;
  localparam logic [MODE_W-1:0] MODE_SPILL       = 3'd2;
  localparam logic [MODE_W-1:0] MODE_BIND        = 3'd3;
  localparam logic [MODE_W-1:0] MODE_RELEASE     = 3'd4;
  localparam logic [MODE_W-1:0] MODE_RELEASE_ALL = 3'd5;
  localparam logic [MODE_W-1:0] MODE_ADD_SPILLED = 3'd6;
  localparam logic [MODE_W-1:0] MODE_NOP         = 3'd7;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NO_FREE   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

  typedef struct packed {
    logic wr;
    logic clr;
    logic clr_all;
  } tbl_cmd_t;

  function automatic logic [OFF_W-1:0] offset_of(input logic [DEPTH_W-1:0] depth);
    logic [OFF_W-1:0] mag;
    mag = OFF_W'(32'(depth) * SLOT_BYTES);
    return OFF_W'(0) - mag;
  endfunction

endpackage

`default_nettype wire

### rtl/vrsm_phys_file.sv
`default_nettype none

module vrsm_phys_file #(
  parameter int NUM_PHYS = 3,
  parameter int PIW      = 2
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic [PIW-1:0]           idx_i,
  input  vrsm_pkg::tbl_cmd_t       cmd_i,
  input  logic [vrsm_pkg::VREG_W-1:0] wdata_i,
  output logic [vrsm_pkg::VREG_W-1:0] rdata_o,
  output logic                     rvalid_o
);
  import vrsm_pkg::*;

  logic [VREG_W-1:0]   owner_q [NUM_PHYS];
  logic [NUM_PHYS-1:0] valid_q;

  assign rdata_o  = owner_q[idx_i];
  assign rvalid_o = valid_q[idx_i];

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr) begin
      owner_q[idx_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (cmd_i.clr_all) begin
      valid_q <= '0;
    end else if (cmd_i.wr) begin
      valid_q[idx_i] <= 1'b1;
    end else if (cmd_i.clr) begin
      valid_q[idx_i] <= 1'b0;
    end
  end

endmodule

`default_nettype wire

### rtl/vrsm_slot_table.sv
`default_nettype none

module vrsm_slot_table #(
  parameter int NUM_SLOTS = 16,
  parameter int SIW       = 4
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [SIW-1:0]              addr_i,
  input  vrsm_pkg::tbl_cmd_t          cmd_i,
  input  logic [vrsm_pkg::VREG_W-1:0] wdata_i,
  output logic [vrsm_pkg::VREG_W-1:0] rdata_o,
  output logic                        rvalid_o
);
  import vrsm_pkg::*;

  logic [VREG_W-1:0]    mem_q [NUM_SLOTS];
  logic [NUM_SLOTS-1:0] valid_q;
  logic [VREG_W-1:0]    rdata_q;
  logic                 rvalid_q;

  assign rdata_o  = rdata_q;
  assign rvalid_o = rvalid_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rvalid_q <= 1'b0;
    end else begin
      rvalid_q <= valid_q[addr_i];
      if (cmd_i.clr_all) begin
        valid_q <= '0;
      end else if (cmd_i.wr) begin
        valid_q[addr_i] <= 1'b1;
      end else if (cmd_i.clr) begin
        valid_q[addr_i] <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

### rtl/virtual_register_spill_map.sv
`default_nettype none

// Register allocator with spill table. A transaction is taken when start is high and busy is
// low; busy then stays high while a sequencer walks the physical registers one per cycle and
// the spill slot memory one per cycle through a single shared owner comparator, and commits
// the update in a final commit state. The result appears for exactly one cycle with done_o, in
// the first cycle in which busy is low again, and cannot be stalled. Release all and the
// no-operation code skip both walks and go straight from start to the commit state.
// A new transaction may be started in the same cycle that done_o is shown.
module virtual_register_spill_map #(
  parameter int NUM_PHYS  = 3,
  parameter int NUM_SLOTS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [vrsm_pkg::MODE_W-1:0]   mode_i,
  input  logic [vrsm_pkg::VREG_W-1:0]   virtual_reg_i,
  input  logic [vrsm_pkg::RIDX_W-1:0]   reg_index_i,
  output logic                          done_o,
  output logic [vrsm_pkg::PREG_W-1:0]   phys_reg_o,
  output logic [vrsm_pkg::STATUS_W-1:0] status_o,
  output logic                          emit_load_o,
  output logic                          emit_store_o,
  output logic signed [vrsm_pkg::OFF_W-1:0] stack_offset_o
);
  import vrsm_pkg::*;

  localparam int PIW = (NUM_PHYS > 1) ? $clog2(NUM_PHYS) : 1;
  localparam int SIW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int SCW = $clog2(NUM_SLOTS + 1);
  localparam logic [PIW-1:0] PHYS_LAST = PIW'(NUM_PHYS - 1);
  localparam logic [SCW-1:0] SLOT_END  = SCW'(NUM_SLOTS);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_PSCAN  = 2'd1;
  localparam logic [1:0] S_SSCAN  = 2'd2;
  localparam logic [1:0] S_COMMIT = 2'd3;

  logic [1:0]          state_q, state_d;
  logic [MODE_W-1:0]   mode_q, mode_d;
  logic [VREG_W-1:0]   vr_q, vr_d;
  logic [RIDX_W-1:0]   ri_q, ri_d;
  logic [PIW-1:0]      pcnt_q, pcnt_d;
  logic [SCW-1:0]      scnt_q, scnt_d;
  logic                rd_pend_q, rd_pend_d;
  logic [SIW-1:0]      rd_tag_q, rd_tag_d;
  logic                pfree_found_q, pfree_found_d;
  logic [PIW-1:0]      pfree_idx_q, pfree_idx_d;
  logic                pmatch_found_q, pmatch_found_d;
  logic [PIW-1:0]      pmatch_idx_q, pmatch_idx_d;
  logic                ri_valid_q, ri_valid_d;
  logic                ri_hit_q, ri_hit_d;
  logic [VREG_W-1:0]   ri_owner_q, ri_owner_d;
  logic                sfree_found_q, sfree_found_d;
  logic [SIW-1:0]      sfree_idx_q, sfree_idx_d;
  logic                smatch_found_q, smatch_found_d;
  logic [SIW-1:0]      smatch_idx_q, smatch_idx_d;
  logic [DEPTH_W-1:0]  depth_q, depth_d;
  logic                done_q, done_d;
  logic [PREG_W-1:0]   preg_q, preg_d;
  logic [STATUS_W-1:0] status_q, status_d;
  logic                load_q, load_d;
  logic                store_q, store_d;
  logic [OFF_W-1:0]    off_q, off_d;

  logic [PIW-1:0]      phys_idx;
  tbl_cmd_t            phys_cmd;
  logic [VREG_W-1:0]   phys_rdata;
  logic                phys_rvalid;
  logic [SIW-1:0]      slot_addr;
  tbl_cmd_t            slot_cmd;
  logic [VREG_W-1:0]   slot_wdata;
  logic [VREG_W-1:0]   slot_rdata;
  logic                slot_rvalid;

  logic [VREG_W-1:0]   cmp_owner;
  logic                cmp_hit;
  logic                ri_ok;
  logic                ri_at_p;
  logic [DEPTH_W-1:0]  spill_depth;

  vrsm_phys_file #(
    .NUM_PHYS(NUM_PHYS),
    .PIW     (PIW)
  ) u_phys (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .idx_i   (phys_idx),
    .cmd_i   (phys_cmd),
    .wdata_i (vr_q),
    .rdata_o (phys_rdata),
    .rvalid_o(phys_rvalid)
  );

  vrsm_slot_table #(
    .NUM_SLOTS(NUM_SLOTS),
    .SIW      (SIW)
  ) u_slots (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .addr_i  (slot_addr),
    .cmd_i   (slot_cmd),
    .wdata_i (slot_wdata),
    .rdata_o (slot_rdata),
    .rvalid_o(slot_rvalid)
  );

  assign busy           = (state_q != S_IDLE);
  assign done_o         = done_q;
  assign phys_reg_o     = preg_q;
  assign status_o       = status_q;
  assign emit_load_o    = load_q;
  assign emit_store_o   = store_q;
  assign stack_offset_o = off_q;

  assign cmp_owner   = (state_q == S_PSCAN) ? phys_rdata : slot_rdata;
  assign cmp_hit     = (cmp_owner == vr_q);
  assign ri_ok       = (32'(ri_q) < NUM_PHYS);
  assign ri_at_p     = (32'(pcnt_q) == 32'(ri_q));
  assign spill_depth = (depth_q < DEPTH_MAX) ? depth_q + 5'd1 : depth_q;

  always_comb begin
    phys_idx = pcnt_q;
    if (state_q == S_COMMIT) begin
      if (mode_q == MODE_GET_FREE || mode_q == MODE_RESTORE) begin
        phys_idx = pfree_idx_q;
      end else begin
        phys_idx = PIW'(ri_q);
      end
    end
  end

  always_comb begin
    slot_addr = scnt_q[SIW-1:0];
    if (state_q == S_COMMIT) begin
      slot_addr = (mode_q == MODE_RESTORE) ? smatch_idx_q : sfree_idx_q;
    end
  end

  always_comb begin
    state_d        = state_q;
    mode_d         = mode_q;
    vr_d           = vr_q;
    ri_d           = ri_q;
    pcnt_d         = pcnt_q;
    scnt_d         = scnt_q;
    rd_pend_d      = 1'b0;
    rd_tag_d       = rd_tag_q;
    pfree_found_d  = pfree_found_q;
    pfree_idx_d    = pfree_idx_q;
    pmatch_found_d = pmatch_found_q;
    pmatch_idx_d   = pmatch_idx_q;
    ri_valid_d     = ri_valid_q;
    ri_hit_d       = ri_hit_q;
    ri_owner_d     = ri_owner_q;
    sfree_found_d  = sfree_found_q;
    sfree_idx_d    = sfree_idx_q;
    smatch_found_d = smatch_found_q;
    smatch_idx_d   = smatch_idx_q;
    depth_d        = depth_q;
    done_d         = 1'b0;
    preg_d         = preg_q;
    status_d       = status_q;
    load_d         = load_q;
    store_d        = store_q;
    off_d          = off_q;
    phys_cmd       = '0;
    slot_cmd       = '0;
    slot_wdata     = vr_q;

    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          mode_d         = mode_i;
          vr_d           = virtual_reg_i;
          ri_d           = reg_index_i;
          pcnt_d         = '0;
          scnt_d         = '0;
          pfree_found_d  = 1'b0;
          pmatch_found_d = 1'b0;
          ri_valid_d     = 1'b0;
          ri_hit_d       = 1'b0;
          sfree_found_d  = 1'b0;
          smatch_found_d = 1'b0;
          if (mode_i == MODE_RELEASE_ALL || mode_i == MODE_NOP) begin
            state_d = S_COMMIT;
          end else begin
            state_d = S_PSCAN;
          end
        end
      end
      S_PSCAN: begin
        if (!phys_rvalid && !pfree_found_q) begin
          pfree_found_d = 1'b1;
          pfree_idx_d   = pcnt_q;
        end
        if (phys_rvalid && cmp_hit && !pmatch_found_q) begin
          pmatch_found_d = 1'b1;
          pmatch_idx_d   = pcnt_q;
        end
        if (ri_at_p) begin
          ri_valid_d = phys_rvalid;
          ri_hit_d   = phys_rvalid && cmp_hit;
          ri_owner_d = phys_rdata;
        end
        if (pcnt_q == PHYS_LAST) begin
          state_d = S_SSCAN;
          scnt_d  = '0;
        end else begin
          pcnt_d = pcnt_q + PIW'(1);
        end
      end
      S_SSCAN: begin
        if (rd_pend_q) begin
          if (!slot_rvalid && !sfree_found_q) begin
            sfree_found_d = 1'b1;
            sfree_idx_d   = rd_tag_q;
          end
          if (slot_rvalid && cmp_hit && !smatch_found_q) begin
            smatch_found_d = 1'b1;
            smatch_idx_d   = rd_tag_q;
          end
        end
        if (scnt_q != SLOT_END) begin
          rd_pend_d = 1'b1;
          rd_tag_d  = scnt_q[SIW-1:0];
          scnt_d    = scnt_q + SCW'(1);
        end else begin
          state_d = S_COMMIT;
        end
      end
      S_COMMIT: begin
        state_d  = S_IDLE;
        done_d   = 1'b1;
        preg_d   = '0;
        status_d = ST_OK;
        load_d   = 1'b0;
        store_d  = 1'b0;
        off_d    = '0;
        unique case (mode_q)
          MODE_GET_FREE: begin
            if (pfree_found_q) begin
              phys_cmd.wr = 1'b1;
              preg_d      = PREG_W'(pfree_idx_q);
            end else begin
              status_d = ST_NO_FREE;
            end
          end
          MODE_RESTORE: begin
            if (pmatch_found_q) begin
              preg_d = PREG_W'(pmatch_idx_q);
            end else if (!smatch_found_q) begin
              status_d = ST_NOT_FOUND;
            end else if (!pfree_found_q) begin
              status_d = ST_NO_FREE;
            end else begin
              phys_cmd.wr  = 1'b1;
              slot_cmd.clr = 1'b1;
              off_d        = offset_of(depth_q);
              depth_d      = (depth_q != '0) ? depth_q - 5'd1 : depth_q;
              load_d       = 1'b1;
              preg_d       = PREG_W'(pfree_idx_q);
            end
          end
          MODE_SPILL: begin
            preg_d = PREG_W'(ri_q);
            if (ri_ok && ri_valid_q) begin
              if (sfree_found_q) begin
                slot_cmd.wr  = 1'b1;
                slot_wdata   = ri_owner_q;
                phys_cmd.clr = 1'b1;
                store_d      = 1'b1;
                off_d        = offset_of(spill_depth);
                depth_d      = spill_depth;
              end else begin
                status_d = ST_FULL;
              end
            end
          end
          MODE_BIND: begin
            preg_d = PREG_W'(ri_q);
            if (ri_ok && !ri_hit_q) begin
              if (ri_valid_q && !sfree_found_q) begin
                status_d = ST_FULL;
              end else begin
                phys_cmd.wr = 1'b1;
                if (ri_valid_q) begin
                  slot_cmd.wr = 1'b1;
                  slot_wdata  = ri_owner_q;
                  store_d     = 1'b1;
                  off_d       = offset_of(spill_depth);
                  depth_d     = spill_depth;
                end
              end
            end
          end
          MODE_RELEASE: begin
            preg_d = PREG_W'(ri_q);
            if (ri_ok) begin
              phys_cmd.clr = 1'b1;
            end
          end
          MODE_RELEASE_ALL: begin
            phys_cmd.clr_all = 1'b1;
            slot_cmd.clr_all = 1'b1;
            depth_d          = '0;
          end
          MODE_ADD_SPILLED: begin
            if (sfree_found_q) begin
              slot_cmd.wr = 1'b1;
            end else begin
              status_d = ST_FULL;
            end
          end
          default: begin
          end
        endcase
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      mode_q         <= '0;
      vr_q           <= '0;
      ri_q           <= '0;
      pcnt_q         <= '0;
      scnt_q         <= '0;
      rd_pend_q      <= 1'b0;
      rd_tag_q       <= '0;
      pfree_found_q  <= 1'b0;
      pfree_idx_q    <= '0;
      pmatch_found_q <= 1'b0;
      pmatch_idx_q   <= '0;
      ri_valid_q     <= 1'b0;
      ri_hit_q       <= 1'b0;
      ri_owner_q     <= '0;
      sfree_found_q  <= 1'b0;
      sfree_idx_q    <= '0;
      smatch_found_q <= 1'b0;
      smatch_idx_q   <= '0;
      depth_q        <= '0;
      done_q         <= 1'b0;
      preg_q         <= '0;
      status_q       <= ST_OK;
      load_q         <= 1'b0;
      store_q        <= 1'b0;
      off_q          <= '0;
    end else begin
      state_q        <= state_d;
      mode_q         <= mode_d;
      vr_q           <= vr_d;
      ri_q           <= ri_d;
      pcnt_q         <= pcnt_d;
      scnt_q         <= scnt_d;
      rd_pend_q      <= rd_pend_d;
      rd_tag_q       <= rd_tag_d;
      pfree_found_q  <= pfree_found_d;
      pfree_idx_q    <= pfree_idx_d;
      pmatch_found_q <= pmatch_found_d;
      pmatch_idx_q   <= pmatch_idx_d;
      ri_valid_q     <= ri_valid_d;
      ri_hit_q       <= ri_hit_d;
      ri_owner_q     <= ri_owner_d;
      sfree_found_q  <= sfree_found_d;
      sfree_idx_q    <= sfree_idx_d;
      smatch_found_q <= smatch_found_d;
      smatch_idx_q   <= smatch_idx_d;
      depth_q        <= depth_d;
      done_q         <= done_d;
      preg_q         <= preg_d;
      status_q       <= status_d;
      load_q         <= load_d;
      store_q        <= store_d;
      off_q          <= off_d;
    end
  end

  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("done_o held for more than one cycle");

  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted transaction did not raise busy");

  a_load_store_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !(emit_load_o && emit_store_o))
    else $error("load and store flagged in one transaction");

  a_fail_no_move: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o != ST_OK) |-> (!emit_load_o && !emit_store_o))
    else $error("failed transaction flagged a load or store");

endmodule

`default_nettype wire
